>>> design/rv32rx_pkg.sv
//==============================================================================
// rv32rx_pkg
// Shared types, operation codes and the ALU function for the R-type execute
// block.
//==============================================================================
`default_nettype none

package rv32rx_pkg;

    localparam int XLEN    = 32;
    localparam int REG_W   = 5;
    localparam int OP_W    = 4;
    localparam int NUM_REGS = 32;

    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
    localparam logic [OP_W-1:0] OP_SLL    = 4'd2;
    localparam logic [OP_W-1:0] OP_SLT    = 4'd3;
    localparam logic [OP_W-1:0] OP_SLTU   = 4'd4;
    localparam logic [OP_W-1:0] OP_XOR    = 4'd5;
    localparam logic [OP_W-1:0] OP_SRL    = 4'd6;
    localparam logic [OP_W-1:0] OP_SRA    = 4'd7;
    localparam logic [OP_W-1:0] OP_OR     = 4'd8;
    localparam logic [OP_W-1:0] OP_AND    = 4'd9;
    localparam logic [OP_W-1:0] OP_DIRECT = 4'd10;

    // Decoded instruction as it travels from the front to the back end
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             writes_rd;   // valid op with rd != x0
        logic             advance_pc;  // register-register op
        logic [REG_W-1:0] rd;
        logic [REG_W-1:0] rs1;
        logic [REG_W-1:0] rs2;
        logic [XLEN-1:0]  wv;
    } uop_t;

    function automatic logic [XLEN-1:0] alu_result(
        input logic [OP_W-1:0] op,
        input logic [XLEN-1:0] a,
        input logic [XLEN-1:0] b,
        input logic [XLEN-1:0] wv
    );
        logic [4:0]      sh;
        logic [XLEN-1:0] r;
        sh = b[4:0];
        case (op)
            OP_ADD:    r = a + b;
            OP_SUB:    r = a - b;
            OP_SLL:    r = a << sh;
            OP_SLT:    r = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
            OP_SLTU:   r = {{(XLEN-1){1'b0}}, (a < b)};
            OP_XOR:    r = a ^ b;
            OP_SRL:    r = a >> sh;
            OP_SRA:    r = $unsigned($signed(a) >>> sh);
            OP_OR:     r = a | b;
            OP_AND:    r = a & b;
            OP_DIRECT: r = wv;
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/rv32rx_if.sv
//==============================================================================
// rv32rx_if
// Valid/ready channels for instruction requests and execute responses.
//==============================================================================
`default_nettype none

interface rv32rx_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [4:0]  dest_index;
    logic [4:0]  src1_index;
    logic [4:0]  src2_index;
    logic [31:0] write_value;

    modport source (
        output valid, operation, dest_index, src1_index, src2_index, write_value,
        input  ready
    );
    modport sink (
        input  valid, operation, dest_index, src1_index, src2_index, write_value,
        output ready
    );
endinterface

interface rv32rx_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic [4:0]  written_index;
    logic [31:0] pc_after;

    modport source (
        output valid, result_value, written_index, pc_after,
        input  ready
    );
    modport sink (
        input  valid, result_value, written_index, pc_after,
        output ready
    );
endinterface

`default_nettype wire

>>> design/rv32rx_front.sv
//==============================================================================
// rv32rx_front
// Accepts request transfers and classifies them into decoded uops.
//==============================================================================
`default_nettype none

module rv32rx_front
    import rv32rx_pkg::*;
(
    rv32rx_req_if.sink req,
    input  wire logic  q_ready,
    output logic       q_push,
    output uop_t       q_uop
);

    logic op_alu;
    logic op_direct;

    always_comb
    begin
        op_alu    = (req.operation <= OP_AND);
        op_direct = (req.operation == OP_DIRECT);
    end

    assign req.ready = q_ready;
    assign q_push    = req.valid & q_ready;

    always_comb
    begin
        q_uop.op         = req.operation;
        q_uop.writes_rd  = (op_alu | op_direct) & (req.dest_index != '0);
        q_uop.advance_pc = op_alu;
        q_uop.rd         = req.dest_index;
        q_uop.rs1        = req.src1_index;
        q_uop.rs2        = req.src2_index;
        q_uop.wv         = req.write_value;
    end

endmodule

`default_nettype wire

>>> design/rv32rx_queue.sv
//==============================================================================
// rv32rx_queue
// Small FIFO of decoded uops between front and back end.
//==============================================================================
`default_nettype none

module rv32rx_queue
    import rv32rx_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire uop_t push_uop,
    output logic      ready,
    input  wire logic pop,
    output logic      head_valid,
    output uop_t      head_uop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    uop_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign ready      = (count_reg != FULL);
    assign head_valid = (count_reg != '0);
    assign head_uop   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_uop;
        end
    end

endmodule

`default_nettype wire

>>> design/rv32rx_back.sv
//==============================================================================
// rv32rx_back
// Register file, operand bypass, ALU, program counter and response register.
//==============================================================================
`default_nettype none

module rv32rx_back
    import rv32rx_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    input  wire uop_t   q_uop,
    output logic        q_pop,
    rv32rx_rsp_if.source rsp
);

    // Register file storage plus per-entry valid bits (cleared at reset)
    logic [XLEN-1:0] rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;

    // Execute stage
    logic            e_valid_reg;
    uop_t            e_uop_reg;
    logic [XLEN-1:0] a_mem_reg, b_mem_reg;
    logic            a_zero_reg, b_zero_reg;
    logic            a_byp_reg,  b_byp_reg;
    logic [XLEN-1:0] byp_data_reg;
    logic [XLEN-1:0] a_op, b_op, e_result;
    logic            e_fire;

    // Write port
    logic             wr_en;
    logic [REG_W-1:0] wr_addr;
    logic [XLEN-1:0]  wr_data;

    // Program counter and response register
    logic [XLEN-1:0]  pc_reg, pc_next;
    logic             out_valid_reg, out_valid_next;
    logic [XLEN-1:0]  out_result_reg;
    logic [REG_W-1:0] out_index_reg;
    logic [XLEN-1:0]  out_pc_reg;

    logic a_hit, b_hit;

    assign e_fire = e_valid_reg & (~out_valid_reg | rsp.ready);
    assign q_pop  = q_valid & (~e_valid_reg | e_fire);

    assign a_op = a_byp_reg ? byp_data_reg : (a_zero_reg ? '0 : a_mem_reg);
    assign b_op = b_byp_reg ? byp_data_reg : (b_zero_reg ? '0 : b_mem_reg);

    assign e_result = alu_result(e_uop_reg.op, a_op, b_op, e_uop_reg.wv);

    assign wr_en   = e_fire & e_uop_reg.writes_rd;
    assign wr_addr = e_uop_reg.rd;
    assign wr_data = e_result;

    // Result written at this edge is not yet in the array; forward it
    assign a_hit = wr_en & (wr_addr == q_uop.rs1);
    assign b_hit = wr_en & (wr_addr == q_uop.rs2);

    assign pc_next = (e_fire && e_uop_reg.advance_pc) ? pc_reg + PC_STEP : pc_reg;
    assign out_valid_next = e_fire | (out_valid_reg & ~rsp.ready);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_addr] <= wr_data;
        end
        if (q_pop)
        begin
            a_mem_reg    <= rf_mem[q_uop.rs1];
            b_mem_reg    <= rf_mem[q_uop.rs2];
            byp_data_reg <= wr_data;
            e_uop_reg    <= q_uop;
        end
        if (e_fire)
        begin
            out_result_reg <= e_uop_reg.writes_rd ? e_result : '0;
            out_index_reg  <= e_uop_reg.writes_rd ? e_uop_reg.rd : '0;
            out_pc_reg     <= pc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg  <= '0;
            e_valid_reg   <= 1'b0;
            a_zero_reg    <= 1'b1;
            b_zero_reg    <= 1'b1;
            a_byp_reg     <= 1'b0;
            b_byp_reg     <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                rf_valid_reg[wr_addr] <= 1'b1;
            end
            if (q_pop)
            begin
                a_byp_reg  <= a_hit;
                b_byp_reg  <= b_hit;
                a_zero_reg <= (q_uop.rs1 == '0) | ~rf_valid_reg[q_uop.rs1];
                b_zero_reg <= (q_uop.rs2 == '0) | ~rf_valid_reg[q_uop.rs2];
            end
            if (q_pop)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_value  = out_result_reg;
    assign rsp.written_index = out_index_reg;
    assign rsp.pc_after      = out_pc_reg;

endmodule

`default_nettype wire

>>> design/rv32_r_type_execute_top.sv
//==============================================================================
// rv32_r_type_execute_top
// RV32I register-register execute block with register file and PC.
//==============================================================================
// Usage:
//   req : one instruction per transfer (operation, rd, rs1, rs2, write_value).
//         Ops 0..9 are add/sub/sll/slt/sltu/xor/srl/sra/or/and; op 10 loads
//         write_value into rd without moving the PC; ops 11..15 are bubbles.
//   rsp : one transfer per request: result written, rd that took it (zero
//         for x0 or a bubble) and the PC after the instruction.
// Path: a request accepted on req passes through queue -> execute stage ->
//   response register before it shows on rsp.
// Throughput: one instruction per cycle while rsp is taken, back to back,
//   including dependent ones; the write of the retiring instruction is
//   forwarded into the operand registers of the next one. The combinational
//   execute-stage ALU and the register file read/write ports set this rate.
// Reset: register file (through per-entry valid bits), PC and all valid
//   flags clear at once; requests are taken from the release of reset on.
// Stall: when rsp is not taken, the response holds, the execute stage
//   holds, and the front queue (QUEUE_DEPTH entries) fills before req.ready
//   drops.
//==============================================================================
`default_nettype none

module rv32_r_type_execute_top
    import rv32rx_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rv32rx_req_if.sink   req,
    rv32rx_rsp_if.source rsp
);

    logic q_ready;
    logic q_push;
    uop_t q_push_uop;
    logic q_pop;
    logic q_valid;
    uop_t q_head_uop;

    // Front: handshake and decode
    rv32rx_front u_front (
        .req     (req),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_uop   (q_push_uop)
    );

    // Decoupling queue
    rv32rx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_uop   (q_push_uop),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_uop   (q_head_uop)
    );

    // Back: operand read, execute, writeback, response
    rv32rx_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_uop   (q_head_uop),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

>>> design/rv32rx_checker.sv
//==============================================================================
// rv32rx_checker
// Port-level checks on the execute block's response channel.
//==============================================================================
`default_nettype none

module rv32rx_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] rsp_result_value,
    input wire logic [4:0]  rsp_written_index,
    input wire logic [31:0] rsp_pc_after
);

    // No response while in reset
    a_no_rsp_in_reset: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
            && $stable(rsp_written_index) && $stable(rsp_pc_after))
        else $error("stalled response changed");

    // x0 or bubble never carries a value
    a_x0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_written_index == 5'd0) |-> (rsp_result_value == 32'd0))
        else $error("nonzero result for x0");

    // PC is word-aligned; it only ever moves in steps of four from zero
    a_pc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_pc_after[1:0] == 2'b00))
        else $error("misaligned pc");

endmodule

bind rv32_r_type_execute_top rv32rx_checker u_rv32rx_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_result_value  (rsp.result_value),
    .rsp_written_index (rsp.written_index),
    .rsp_pc_after      (rsp.pc_after)
);

`default_nettype wire

>>> tb/tb_top.sv
//==============================================================================
// tb_top
// Self-checking bench for the RV32I register-register execute block.
//------------------------------------------------------------------------------
// Instructions are sent over the request channel. A shadow register file and
// PC in the bench work out the response to each accepted transfer. A checker
// process compares every response transfer with the oldest expected one.
// The directed tests cover operand extremes, every operation, x0 as the
// destination and bubble opcodes. The random tests follow them, with idle
// cycles on both channels, a drain pause and a back-to-back stretch.
//==============================================================================
`timescale 1ns / 1ps

module tb_top
    import rv32rx_pkg::*;
();

    // Opcodes 11..15 are not defined instructions; the block treats them as
    // bubbles that retire with no write and no PC movement.
    localparam logic [OP_W-1:0] OP_BUBBLE_LO = 4'd11;
    localparam logic [OP_W-1:0] OP_BUBBLE_HI = 4'd15;

    localparam int IDLE_PCT    = 30;   // chance of an idle cycle per side
    localparam int MAX_REPORTS = 10;   // mismatches printed before going quiet
    localparam int TAIL_CYCLES = 8;    // settle time after the last response

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [REG_W-1:0] dest;
        logic [REG_W-1:0] src1;
        logic [REG_W-1:0] src2;
        logic [XLEN-1:0]  write_value;
    } instr_t;

    typedef struct packed {
        logic [XLEN-1:0]  value;
        logic [REG_W-1:0] index;
        logic [XLEN-1:0]  pc;
    } retire_t;

    logic clk;
    logic rst_n;

    rv32rx_req_if req_if();
    rv32rx_rsp_if rsp_if();

    rv32_r_type_execute_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // Shadow architectural state, updated in transfer order on the request side.
    logic [XLEN-1:0] shadow_regs [NUM_REGS];
    logic [XLEN-1:0] shadow_pc;

    // Responses still owed by the block, oldest first.
    retire_t pending_retires [$];

    int  mismatch_count;
    bit  sender_idle_en;
    bit  receiver_stall_en;

    //--------------------------------------------------------------------------
    // Clock and run limit
    //--------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The limit stays well clear of a run with both sides stalling; reaching it reports a failure.
    initial
    begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    //--------------------------------------------------------------------------
    // Shadow model of the execute stage
    //--------------------------------------------------------------------------
    function automatic logic [XLEN-1:0] read_shadow(input logic [REG_W-1:0] idx);
        return (idx == '0) ? '0 : shadow_regs[idx];
    endfunction

    // Works out the response for one instruction and commits its effects.
    function automatic retire_t retire_instr(input instr_t it);
        logic [XLEN-1:0]   a;
        logic [XLEN-1:0]   b;
        logic [4:0]        shamt;
        logic [2*XLEN-1:0] sext;
        logic [XLEN-1:0]   r;
        logic              writes;
        logic              advance;
        retire_t           res;

        a       = read_shadow(it.src1);
        b       = read_shadow(it.src2);
        shamt   = b[4:0];
        sext    = {{XLEN{a[XLEN-1]}}, a};
        r       = '0;
        writes  = 1'b1;
        advance = 1'b1;

        case (it.operation)
            OP_ADD:    r = a + b;
            OP_SUB:    r = a - b;
            OP_SLL:    r = a << shamt;
            // flipping the sign bits lets an unsigned compare give the signed result
            OP_SLT:    r = XLEN'(({~a[XLEN-1], a[XLEN-2:0]} < {~b[XLEN-1], b[XLEN-2:0]}));
            OP_SLTU:   r = XLEN'((a < b));
            OP_XOR:    r = a ^ b;
            OP_SRL:    r = a >> shamt;
            // window into the sign-extended value gives the arithmetic shift
            OP_SRA:    r = sext[shamt +: XLEN];
            OP_OR:     r = a | b;
            OP_AND:    r = a & b;
            OP_DIRECT:
            begin
                r       = it.write_value;
                advance = 1'b0;
            end
            default:
            begin
                writes  = 1'b0;
                advance = 1'b0;
            end
        endcase

        if (!writes || it.dest == '0)
        begin
            res.value = '0;
            res.index = '0;
        end
        else
        begin
            shadow_regs[it.dest] = r;
            res.value = r;
            res.index = it.dest;
        end

        if (advance)
            shadow_pc = shadow_pc + PC_STEP;
        res.pc = shadow_pc;
        return res;
    endfunction

    //--------------------------------------------------------------------------
    // Request side
    //--------------------------------------------------------------------------
    // Sends one instruction. Valid is left high on return so the next call can
    // keep it up for a back-to-back transfer or drop it for an idle cycle.
    task automatic send_instr(input logic [OP_W-1:0]  op,
                              input logic [REG_W-1:0] rd,
                              input logic [REG_W-1:0] rs1,
                              input logic [REG_W-1:0] rs2,
                              input logic [XLEN-1:0]  wv);
        instr_t it;
        it = '{operation: op, dest: rd, src1: rs1, src2: rs2, write_value: wv};

        while (sender_idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end

        req_if.valid       <= 1'b1;
        req_if.operation   <= it.operation;
        req_if.dest_index  <= it.dest;
        req_if.src1_index  <= it.src1;
        req_if.src2_index  <= it.src2;
        req_if.write_value <= it.write_value;

        do
            @(posedge clk);
        while (!req_if.ready);

        // transfer taken at this edge: predict in acceptance order
        pending_retires.push_back(retire_instr(it));
    endtask

    // Stops sending and holds off until every owed response has come back.
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        while (pending_retires.size() != 0)
            @(posedge clk);
    endtask

    //--------------------------------------------------------------------------
    // Response side: random backpressure and the checker
    //--------------------------------------------------------------------------
    task automatic check_response();
        retire_t got;
        retire_t want;

        got.value = rsp_if.result_value;
        got.index = rsp_if.written_index;
        got.pc    = rsp_if.pc_after;

        if (pending_retires.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected response: value=%08h rd=%0d pc=%08h",
                         got.value, got.index, got.pc);
            return;
        end

        want = pending_retires.pop_front();
        if (got.value !== want.value || got.index !== want.index || got.pc !== want.pc)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display({"mismatch: expected value=%08h rd=%0d pc=%08h,",
                          " got value=%08h rd=%0d pc=%08h"},
                         want.value, want.index, want.pc, got.value, got.index, got.pc);
        end
    endtask

    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
                check_response();
            rsp_if.ready <= !(receiver_stall_en && $urandom_range(99) < IDLE_PCT);
        end
    end

    //--------------------------------------------------------------------------
    // Random stimulus helpers
    //--------------------------------------------------------------------------
    // Operand values lean on the corners: zero, all ones, the sign boundary
    // and small numbers that make useful shift amounts.
    function automatic logic [XLEN-1:0] rand_data();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return XLEN'($urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    // Most instructions are real ALU ops; direct writes seed fresh values,
    // and a few bubbles are mixed in.
    function automatic logic [OP_W-1:0] rand_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return OP_DIRECT;
        if (pick < 22)
            return OP_W'($urandom_range(OP_BUBBLE_HI, OP_BUBBLE_LO));
        return OP_W'($urandom_range(OP_AND, OP_ADD));
    endfunction

    // A narrow register window (x0..x3) makes instructions often depend on the
    // one just before it, which exercises the forwarding path.
    function automatic logic [REG_W-1:0] rand_reg(input bit narrow);
        return narrow ? REG_W'($urandom_range(3)) : REG_W'($urandom_range(NUM_REGS - 1));
    endfunction

    task automatic send_random(input int count, input bit narrow);
        for (int i = 0; i < count; i++)
            send_instr(rand_op(), rand_reg(narrow), rand_reg(narrow), rand_reg(narrow),
                       rand_data());
    endtask

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------
    // Loads corner values, then runs each ALU op on them. Non-direct ops carry
    // a junk write_value that must be ignored.
    task automatic test_each_operation();
        send_instr(OP_DIRECT, 5'd1, 5'd0, 5'd0, 32'hffff_ffff);
        send_instr(OP_DIRECT, 5'd2, 5'd0, 5'd0, 32'h8000_0000);
        send_instr(OP_DIRECT, 5'd3, 5'd0, 5'd0, 32'h7fff_ffff);
        send_instr(OP_DIRECT, 5'd4, 5'd0, 5'd0, 32'h0000_0001);
        send_instr(OP_DIRECT, 5'd5, 5'd0, 5'd0, 32'h0000_001f);
        send_instr(OP_DIRECT, 5'd6, 5'd0, 5'd0, 32'hffff_ffe0);   // shift amount 0

        send_instr(OP_ADD,  5'd7,  5'd1, 5'd4, $urandom);   // wraps to zero
        send_instr(OP_SUB,  5'd8,  5'd0, 5'd4, $urandom);   // borrows to all ones
        send_instr(OP_SLL,  5'd9,  5'd4, 5'd5, $urandom);
        send_instr(OP_SLT,  5'd10, 5'd2, 5'd3, $urandom);   // negative < positive
        send_instr(OP_SLTU, 5'd11, 5'd2, 5'd3, $urandom);   // not as unsigned
        send_instr(OP_XOR,  5'd12, 5'd1, 5'd3, $urandom);
        send_instr(OP_SRL,  5'd13, 5'd2, 5'd5, $urandom);
        send_instr(OP_SRA,  5'd14, 5'd2, 5'd5, $urandom);
        send_instr(OP_SRA,  5'd15, 5'd2, 5'd6, $urandom);   // only low 5 bits count
        send_instr(OP_OR,   5'd16, 5'd2, 5'd4, $urandom);
        send_instr(OP_AND,  5'd31, 5'd1, 5'd3, $urandom);
        send_instr(OP_ADD,  5'd30, 5'd31, 5'd31, $urandom);
    endtask

    // Writes to x0 are dropped but the PC still moves (held for a direct
    // write); bubbles change nothing.
    task automatic test_x0_and_bubbles();
        send_instr(OP_ADD,       5'd0,  5'd1, 5'd4, $urandom);
        send_instr(OP_DIRECT,    5'd0,  5'd0, 5'd0, 32'hdead_beef);
        send_instr(OP_ADD,       5'd17, 5'd0, 5'd4, $urandom);   // x0 still reads 0
        send_instr(OP_BUBBLE_LO, 5'd18, 5'd1, 5'd1, 32'hffff_ffff);
        send_instr(OP_BUBBLE_HI, 5'd31, 5'd31, 5'd31, 32'hffff_ffff);
        send_instr(OP_OR,        5'd18, 5'd18, 5'd0, $urandom);  // bubble left x18 alone
    endtask

    task automatic test_random_traffic(input int count);
        sender_idle_en    = 1'b1;
        receiver_stall_en = 1'b1;
        send_random(count, 1'b0);
    endtask

    // Dependent chains over a few registers, sent and drained at full rate.
    task automatic test_back_to_back(input int count);
        sender_idle_en    = 1'b0;
        receiver_stall_en = 1'b0;
        send_random(count, 1'b1);
        sender_idle_en    = 1'b1;
        receiver_stall_en = 1'b1;
    endtask

    // Starts sending again with the pipeline empty after a full drain.
    task automatic test_drain_pause(input int count);
        send_random(count, 1'b1);
        wait_for_drain();
        send_random(count, 1'b0);
    endtask

    //--------------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------------
    initial
    begin
        mismatch_count    = 0;
        sender_idle_en    = 1'b1;
        receiver_stall_en = 1'b1;
        for (int i = 0; i < NUM_REGS; i++)
            shadow_regs[i] = '0;
        shadow_pc = '0;

        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.operation   <= OP_ADD;
        req_if.dest_index  <= '0;
        req_if.src1_index  <= '0;
        req_if.src2_index  <= '0;
        req_if.write_value <= '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_each_operation();
        test_x0_and_bubbles();
        test_random_traffic(250);
        test_drain_pause(40);
        test_back_to_back(200);
        test_random_traffic(180);

        wait_for_drain();
        // let any stray response from the queue, execute stage or response register surface
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_retires.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
